[src/arnp_pkg.sv]
// Shared types, codes and helper function of the ASCII radix number parser.
package arnp_pkg;

	localparam int unsigned POSITION_MAX_DEF = 255;
	localparam int unsigned RADIX_W = 5;
	localparam int unsigned ACC_W = 32;
	localparam int unsigned VALUE_W = 33;
	localparam int unsigned EPOS_W = 8;

	localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd10;
	localparam logic [RADIX_W-1:0] RADIX_LIMIT = 5'd16;
	localparam logic [RADIX_W-1:0] DIGIT_NONE = 5'd16;

	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_MINUS = 8'h2d;
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_NINE = 8'h39;
	localparam logic [7:0] CH_LOWER_A = 8'h61;
	localparam logic [7:0] CH_LOWER_F = 8'h66;
	localparam logic [7:0] CH_UPPER_A = 8'h41;
	localparam logic [7:0] CH_UPPER_F = 8'h46;

	typedef enum logic [1:0] {
		REG_RADIX = 2'd0,
		REG_DIGIT_CASE = 2'd1,
		REG_RELAXED = 2'd2,
		REG_SIGNED_MODE = 2'd3
	} reg_index_t;

	typedef enum logic [1:0] {
		CASE_LOWER = 2'd0,
		CASE_UPPER = 2'd1,
		CASE_ANY = 2'd2,
		CASE_ANY_EMPTY_ZERO = 2'd3
	} digit_case_t;

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_BAD_DIGIT = 2'd1,
		ST_ABOVE_32 = 2'd2,
		ST_SIGNED_RANGE = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		PH_START = 2'd0,
		PH_LEAD = 2'd1,
		PH_DIGITS = 2'd2,
		PH_TRAIL = 2'd3
	} phase_t;

	typedef enum logic [2:0] {
		ACT_NONE,
		ACT_MINUS,
		ACT_DIGIT,
		ACT_COUNT,
		ACT_TRAIL_START,
		ACT_BAD_HERE,
		ACT_BAD_TRAIL
	} action_t;

	typedef struct packed {
		logic [RADIX_W-1:0] radix;
		digit_case_t digit_case;
		logic relaxed;
		logic signed_mode;
	} cfg_t;

	// Parse state flags as they stand after the current beat.
	typedef struct packed {
		logic go;
		logic last;
		logic over_range;
		logic negative;
		logic bad_seen;
		logic digits_seen;
		logic partial_over;
	} step_t;

	// Digit value of a character under the case rule, DIGIT_NONE if not a digit.
	function automatic logic [RADIX_W-1:0] digit_of(input logic [7:0] c, input digit_case_t dc);
		logic lo;
		logic up;
		logic [7:0] d;
		lo = (dc != CASE_UPPER);
		up = (dc != CASE_LOWER);
		d = 8'(DIGIT_NONE);
		if (c >= CH_ZERO && c <= CH_NINE) begin
			d = c - CH_ZERO;
		end else if (lo && c >= CH_LOWER_A && c <= CH_LOWER_F) begin
			d = c - CH_LOWER_A + 8'd10;
		end else if (up && c >= CH_UPPER_A && c <= CH_UPPER_F) begin
			d = c - CH_UPPER_A + 8'd10;
		end
		return d[RADIX_W-1:0];
	endfunction

endpackage

[src/arnp_cfg_regs.sv]
// Configuration registers of the number parser.
module arnp_cfg_regs (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_wr_en,
	input  logic [1:0] cfg_index,
	input  logic [arnp_pkg::RADIX_W-1:0] cfg_data,
	output arnp_pkg::cfg_t cfg
);
	import arnp_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.radix <= RADIX_RESET;
			cfg_q.digit_case <= CASE_ANY;
			cfg_q.relaxed <= 1'b1;
			cfg_q.signed_mode <= 1'b0;
		end else if (cfg_wr_en) begin
			unique case (reg_index_t'(cfg_index))
				REG_RADIX: cfg_q.radix <= cfg_data;
				REG_DIGIT_CASE: cfg_q.digit_case <= digit_case_t'(cfg_data[1:0]);
				REG_RELAXED: cfg_q.relaxed <= cfg_data[0];
				REG_SIGNED_MODE: cfg_q.signed_mode <= cfg_data[0];
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

[src/arnp_parse_core.sv]
// Input register and per-character parse state with its update logic.
module arnp_parse_core #(
	parameter int unsigned POSITION_MAX = arnp_pkg::POSITION_MAX_DEF,
	parameter int unsigned POS_W = $clog2(POSITION_MAX + 1)
) (
	input  logic clk,
	input  logic arst_n,
	input  arnp_pkg::cfg_t cfg,
	input  logic in_valid,
	output logic in_stall,
	input  logic [7:0] char_code,
	input  logic char_present,
	input  logic last,
	input  logic out_free,
	output arnp_pkg::step_t step,
	output logic [arnp_pkg::ACC_W-1:0] acc_d,
	output logic [arnp_pkg::ACC_W-1:0] partial_d,
	output logic [POS_W-1:0] bad_pos_d
);
	import arnp_pkg::*;

	localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(POSITION_MAX);
	localparam int unsigned PROD_W = ACC_W + RADIX_W;

	logic valid_s1;
	logic [7:0] char_s1;
	logic present_s1;
	logic last_s1;
	logic go;

	phase_t phase_q, phase_d;
	logic [ACC_W-1:0] acc_q, partial_q;
	logic over_q, over_d;
	logic neg_q, neg_d;
	logic bad_q, bad_d;
	logic digits_q, digits_d;
	logic pover_q, pover_d;
	logic [POS_W-1:0] pos_q, pos_d, pos_inc;
	logic [POS_W-1:0] fts_q, fts_d;
	logic [POS_W-1:0] bad_pos_q;

	action_t act;
	logic active;
	logic is_ws;
	logic is_minus;
	logic [RADIX_W-1:0] digit;
	logic digit_ok;
	logic [PROD_W-1:0] prod;

	// A closing beat waits in the input register until the result register is free.
	assign go = valid_s1 && (!last_s1 || out_free);
	assign in_stall = valid_s1 && !go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			char_s1 <= char_code;
			present_s1 <= char_present;
			last_s1 <= last;
		end
	end

	assign active = go && present_s1 && !bad_q;
	assign is_ws = (char_s1 == CH_SPACE) || (char_s1 == CH_TAB);
	assign is_minus = (char_s1 == CH_MINUS);
	assign digit = digit_of(char_s1, cfg.digit_case);
	assign digit_ok = (digit != DIGIT_NONE) && (digit < cfg.radix);

	// Next phase and the action for this character.
	always_comb begin
		phase_d = phase_q;
		act = ACT_NONE;
		if (active) begin
			unique case (phase_q)
				PH_START, PH_LEAD: begin
					if (is_ws) begin
						phase_d = PH_LEAD;
					end else if (is_minus && cfg.signed_mode && !neg_q &&
							(phase_q == PH_START || cfg.digit_case == CASE_ANY)) begin
						act = ACT_MINUS;
						phase_d = PH_LEAD;
					end else if (digit_ok) begin
						act = ACT_DIGIT;
						phase_d = PH_DIGITS;
					end else begin
						act = ACT_BAD_HERE;
					end
				end
				PH_DIGITS: begin
					if (is_ws) begin
						act = ACT_TRAIL_START;
						phase_d = PH_TRAIL;
					end else if (digit_ok) begin
						act = ACT_DIGIT;
					end else begin
						act = ACT_BAD_HERE;
					end
				end
				PH_TRAIL: begin
					act = is_ws ? ACT_COUNT : ACT_BAD_TRAIL;
				end
				default: phase_d = phase_q;
			endcase
		end
	end

	assign pos_inc = (pos_q < POS_LIMIT) ? pos_q + 1'b1 : pos_q;
	assign prod = PROD_W'(acc_q) * PROD_W'(cfg.radix) + PROD_W'(digit);

	// Datapath updates driven by the action.
	always_comb begin
		acc_d = acc_q;
		over_d = over_q;
		neg_d = neg_q;
		bad_d = bad_q;
		digits_d = digits_q;
		pover_d = pover_q;
		pos_d = pos_q;
		fts_d = fts_q;
		bad_pos_d = bad_pos_q;
		partial_d = partial_q;
		if (act != ACT_NONE && act != ACT_MINUS) begin
			pos_d = pos_inc;
			digits_d = 1'b1;
		end
		case (act)
			ACT_MINUS: neg_d = 1'b1;
			ACT_DIGIT: begin
				acc_d = prod[ACC_W-1:0];
				over_d = over_q || (prod[PROD_W-1:ACC_W] != '0);
			end
			ACT_TRAIL_START: fts_d = pos_inc;
			ACT_BAD_HERE, ACT_BAD_TRAIL: begin
				bad_d = 1'b1;
				bad_pos_d = (act == ACT_BAD_HERE) ? pos_inc : fts_q;
				partial_d = acc_q;
				pover_d = over_q;
			end
			default: acc_d = acc_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_START;
			acc_q <= '0;
			over_q <= 1'b0;
			neg_q <= 1'b0;
			bad_q <= 1'b0;
			digits_q <= 1'b0;
			pover_q <= 1'b0;
			pos_q <= '0;
			fts_q <= '0;
			bad_pos_q <= '0;
			partial_q <= '0;
		end else if (go && last_s1) begin
			// The text is closed: start the next one from scratch.
			phase_q <= PH_START;
			acc_q <= '0;
			over_q <= 1'b0;
			neg_q <= 1'b0;
			bad_q <= 1'b0;
			digits_q <= 1'b0;
			pover_q <= 1'b0;
			pos_q <= '0;
			fts_q <= '0;
			bad_pos_q <= '0;
			partial_q <= '0;
		end else begin
			phase_q <= phase_d;
			acc_q <= acc_d;
			over_q <= over_d;
			neg_q <= neg_d;
			bad_q <= bad_d;
			digits_q <= digits_d;
			pover_q <= pover_d;
			pos_q <= pos_d;
			fts_q <= fts_d;
			bad_pos_q <= bad_pos_d;
			partial_q <= partial_d;
		end
	end

	assign step.go = go;
	assign step.last = last_s1;
	assign step.over_range = over_d;
	assign step.negative = neg_d;
	assign step.bad_seen = bad_d;
	assign step.digits_seen = digits_d;
	assign step.partial_over = pover_d;

endmodule

[src/arnp_result.sv]
// Final decision on a closing beat and the result register.
module arnp_result #(
	parameter int unsigned POS_W = 8
) (
	input  logic clk,
	input  logic arst_n,
	input  arnp_pkg::cfg_t cfg,
	input  arnp_pkg::step_t step,
	input  logic [arnp_pkg::ACC_W-1:0] acc_d,
	input  logic [arnp_pkg::ACC_W-1:0] partial_d,
	input  logic [POS_W-1:0] bad_pos_d,
	output logic out_free,
	output logic out_valid,
	input  logic out_stall,
	output logic [1:0] status,
	output logic signed [arnp_pkg::VALUE_W-1:0] value,
	output logic value_assigned,
	output logic [arnp_pkg::EPOS_W-1:0] error_position
);
	import arnp_pkg::*;

	logic valid_s2;
	status_t status_s2, st;
	logic [VALUE_W-1:0] value_s2, val;
	logic assigned_s2, asg;
	logic [EPOS_W-1:0] epos_s2, epos;
	logic [POS_W+EPOS_W-1:0] pos_ext;
	logic load;

	assign out_free = !valid_s2 || !out_stall;
	assign load = step.go && step.last;
	assign pos_ext = {{EPOS_W{1'b0}}, bad_pos_d};

	always_comb begin
		st = ST_OK;
		val = '0;
		asg = 1'b0;
		epos = '0;
		if (cfg.radix > RADIX_LIMIT) begin
			st = ST_BAD_DIGIT;
		end else if (step.bad_seen) begin
			epos = pos_ext[EPOS_W-1:0];
			st = step.partial_over ? ST_ABOVE_32 : ST_BAD_DIGIT;
			if (cfg.relaxed && !cfg.signed_mode) begin
				asg = 1'b1;
				val = step.partial_over ? '0 : {1'b0, partial_d};
			end
		end else if (!step.digits_seen) begin
			if (cfg.digit_case == CASE_ANY_EMPTY_ZERO) begin
				asg = 1'b1;
			end else begin
				st = ST_BAD_DIGIT;
			end
		end else if (step.over_range) begin
			st = ST_ABOVE_32;
			asg = !cfg.signed_mode;
		end else if (!cfg.signed_mode) begin
			asg = 1'b1;
			val = {1'b0, acc_d};
		end else if (acc_d >= 32'h7fff_ffff) begin
			st = ST_SIGNED_RANGE;
		end else begin
			asg = 1'b1;
			val = step.negative ? VALUE_W'(0) - {1'b0, acc_d} : {1'b0, acc_d};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (load) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			status_s2 <= st;
			value_s2 <= val;
			assigned_s2 <= asg;
			epos_s2 <= epos;
		end
	end

	assign out_valid = valid_s2;
	assign status = status_s2;
	assign value = $signed(value_s2);
	assign value_assigned = assigned_s2;
	assign error_position = epos_s2;

endmodule

[src/ascii_radix_number_parser_unit.sv]
// Top level of the ASCII radix number parser.
//
// The input channel carries one character of a text number per beat
// (char_code, char_present, last). Beats without last give no result; the
// beat with last gives exactly one result beat (status, value,
// value_assigned, error_position) on the output channel.
// Every beat is captured in an input register; from there the parse state is
// updated, with one multiply-add by the radix for a digit, and, on a closing
// beat, the final decision is written into the result register once that
// register is free, so a result is presented from the result register once
// its closing beat has left the input register. One beat is accepted every
// cycle as long as results are taken.
// When the receiver stalls, a waiting result holds; further characters keep
// flowing until a second closing beat reaches the input register, which then
// stalls the sender until the result register empties.
// Configuration is written through cfg_wr_en, cfg_index and cfg_data while
// no text is in flight. Reset clears both channels, the parse state and
// loads radix 10, any case, relaxed on and signed mode off.
module ascii_radix_number_parser_unit #(
	parameter int unsigned POSITION_MAX = arnp_pkg::POSITION_MAX_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_wr_en,
	input  logic [1:0] cfg_index,
	input  logic [arnp_pkg::RADIX_W-1:0] cfg_data,
	input  logic in_valid,
	output logic in_stall,
	input  logic [7:0] char_code,
	input  logic char_present,
	input  logic last,
	output logic out_valid,
	input  logic out_stall,
	output logic [1:0] status,
	output logic signed [arnp_pkg::VALUE_W-1:0] value,
	output logic value_assigned,
	output logic [arnp_pkg::EPOS_W-1:0] error_position
);
	import arnp_pkg::*;

	localparam int unsigned POS_W = $clog2(POSITION_MAX + 1);

	cfg_t cfg;
	step_t step;
	logic out_free;
	logic [ACC_W-1:0] acc_d;
	logic [ACC_W-1:0] partial_d;
	logic [POS_W-1:0] bad_pos_d;

	arnp_cfg_regs u_cfg (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.cfg(cfg)
	);

	arnp_parse_core #(
		.POSITION_MAX(POSITION_MAX),
		.POS_W(POS_W)
	) u_core (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.char_code(char_code),
		.char_present(char_present),
		.last(last),
		.out_free(out_free),
		.step(step),
		.acc_d(acc_d),
		.partial_d(partial_d),
		.bad_pos_d(bad_pos_d)
	);

	arnp_result #(
		.POS_W(POS_W)
	) u_result (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg),
		.step(step),
		.acc_d(acc_d),
		.partial_d(partial_d),
		.bad_pos_d(bad_pos_d),
		.out_free(out_free),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.value(value),
		.value_assigned(value_assigned),
		.error_position(error_position)
	);

endmodule
